[hw/rtl/slrh_pkg.sv]
// Package for the serial link role handshake block.
// Holds field widths, register map, side and connection codes and reset values.
// No dependencies.
package slrh_pkg;

  // Field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CodeW     = 2;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned RegIdxW   = 3;

  // Register indexes (byte address is 4 times the index)
  typedef enum logic [RegIdxW-1:0] {
    REG_SYNC_BYTE    = 3'd0,
    REG_ACK_BYTE     = 3'd1,
    REG_MASTER_TICKS = 3'd2,
    REG_SLAVE_TICKS  = 3'd3,
    REG_ACK_TICKS    = 3'd4
  } reg_idx_e;

  // Register reset values
  localparam logic [ByteW-1:0] SyncByteRst    = 8'hAA;
  localparam logic [ByteW-1:0] AckByteRst     = 8'h55;
  localparam logic [ByteW-1:0] MasterTicksRst = 8'd3;
  localparam logic [ByteW-1:0] SlaveTicksRst  = 8'd30;
  localparam logic [ByteW-1:0] AckTicksRst    = 8'd60;

  // Link side codes
  typedef enum logic [CodeW-1:0] {
    SIDE_NONE   = 2'd0,
    SIDE_MASTER = 2'd1,
    SIDE_SLAVE  = 2'd2
  } side_e;

  // Connection state codes
  typedef enum logic [CodeW-1:0] {
    CONN_DOWN   = 2'd0,
    CONN_TRYING = 2'd1,
    CONN_UP     = 2'd2
  } conn_e;

endpackage

[hw/rtl/serial_link_role_handshake_top.sv]
// Top level of the serial link role handshake block.
// Uses slrh_pkg for widths, register map and codes.
//
// The block takes one request per tick and returns one result per tick. Each
// request is processed in the cycle it is accepted: the phase state machine
// updates and the result is written to the output register, so a new request
// can be taken every clock cycle as long as the output register is empty or is
// being drained. Restart has priority and returns the link to disconnected idle
// with the transfer aborted. The user must write the configuration registers
// over the APB port only while no request is in flight; the block itself does
// not enforce this.
module serial_link_role_handshake_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request stream. tdata: restart [0], transfer_done [1], received_byte [9:2]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [slrh_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream. tdata: start_transfer [0], send_byte [8:1], internal_clock [9],
  // abort_transfer [10], link_state [12:11], link_side [14:13]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [slrh_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [slrh_pkg::ApbAddrW-1:0]      paddr,
  input  logic [slrh_pkg::ApbDataW-1:0]      pwdata,
  output logic [slrh_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);
  import slrh_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_MASTER_GO   = 3'd1,
    PH_MASTER_WAIT = 3'd2,
    PH_SLAVE_GO    = 3'd3,
    PH_SLAVE_WAIT  = 3'd4,
    PH_ACK_GO      = 3'd5,
    PH_ACK_WAIT    = 3'd6
  } phase_e;

  // Configuration registers
  logic [ByteW-1:0] sync_byte_q, ack_byte_q, master_ticks_q, slave_ticks_q, ack_ticks_q;
  logic [RegIdxW-1:0] reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q    <= SyncByteRst;
      ack_byte_q     <= AckByteRst;
      master_ticks_q <= MasterTicksRst;
      slave_ticks_q  <= SlaveTicksRst;
      ack_ticks_q    <= AckTicksRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SYNC_BYTE:    sync_byte_q    <= pwdata[ByteW-1:0];
        REG_ACK_BYTE:     ack_byte_q     <= pwdata[ByteW-1:0];
        REG_MASTER_TICKS: master_ticks_q <= pwdata[ByteW-1:0];
        REG_SLAVE_TICKS:  slave_ticks_q  <= pwdata[ByteW-1:0];
        REG_ACK_TICKS:    ack_ticks_q    <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SYNC_BYTE:    prdata[ByteW-1:0] = sync_byte_q;
      REG_ACK_BYTE:     prdata[ByteW-1:0] = ack_byte_q;
      REG_MASTER_TICKS: prdata[ByteW-1:0] = master_ticks_q;
      REG_SLAVE_TICKS:  prdata[ByteW-1:0] = slave_ticks_q;
      REG_ACK_TICKS:    prdata[ByteW-1:0] = ack_ticks_q;
      default:          prdata = '0;
    endcase
  end

  // Handshake state
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] ticks_q, ticks_d;
  side_e            side_q, side_d;
  conn_e            conn_q, conn_d;

  // Output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic accept;
  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Request fields
  logic             in_restart, in_done;
  logic [ByteW-1:0] in_rx, ticks_inc;
  assign in_restart = s_axis_tdata[0];
  assign in_done    = s_axis_tdata[1];
  assign in_rx      = s_axis_tdata[9:2];
  assign ticks_inc  = ticks_q + 8'd1;

  logic             start, iclk, abort_x;
  logic [ByteW-1:0] tx;

  // Next-state and result logic for one tick
  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    side_d  = side_q;
    conn_d  = conn_q;
    start   = 1'b0;
    tx      = '0;
    iclk    = 1'b0;
    abort_x = 1'b0;
    if (in_restart) begin
      phase_d = PH_IDLE;
      ticks_d = '0;
      side_d  = SIDE_NONE;
      conn_d  = CONN_DOWN;
      abort_x = 1'b1;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          conn_d  = CONN_TRYING;
          phase_d = PH_MASTER_GO;
        end
        PH_MASTER_GO: begin
          start   = 1'b1;
          tx      = sync_byte_q;
          iclk    = 1'b1;
          ticks_d = '0;
          phase_d = PH_MASTER_WAIT;
        end
        PH_MASTER_WAIT: begin
          ticks_d = ticks_inc;
          if (in_done) begin
            if (in_rx == sync_byte_q) begin
              side_d  = SIDE_MASTER;
              phase_d = PH_ACK_GO;
            end else begin
              phase_d = PH_SLAVE_GO;
            end
          end else if (ticks_inc >= master_ticks_q) begin
            abort_x = 1'b1;
            phase_d = PH_SLAVE_GO;
          end
        end
        PH_SLAVE_GO: begin
          start   = 1'b1;
          tx      = sync_byte_q;
          ticks_d = '0;
          phase_d = PH_SLAVE_WAIT;
        end
        PH_SLAVE_WAIT: begin
          ticks_d = ticks_inc;
          if (in_done) begin
            if (in_rx == sync_byte_q) begin
              side_d  = SIDE_SLAVE;
              phase_d = PH_ACK_GO;
            end else begin
              phase_d = PH_MASTER_GO;
            end
          end else if (ticks_inc >= slave_ticks_q) begin
            abort_x = 1'b1;
            phase_d = PH_MASTER_GO;
          end
        end
        PH_ACK_GO: begin
          start   = 1'b1;
          tx      = ack_byte_q;
          iclk    = (side_q == SIDE_MASTER);
          ticks_d = '0;
          phase_d = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          ticks_d = ticks_inc;
          if (in_done) begin
            if ((in_rx == ack_byte_q) || (in_rx == sync_byte_q)) begin
              conn_d  = CONN_UP;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_MASTER_GO;
            end
          end else if (ticks_inc >= ack_ticks_q) begin
            abort_x = 1'b1;
            phase_d = PH_MASTER_GO;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    m_data_d = {1'b0, side_d, conn_d, abort_x, iclk, tx, start};
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ticks_q   <= '0;
      side_q    <= SIDE_NONE;
      conn_q    <= CONN_DOWN;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        ticks_q   <= ticks_d;
        side_q    <= side_d;
        conn_q    <= conn_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[dv/tb.sv]
// Testbench for serial_link_role_handshake_top: drives tick requests and APB writes.
// A scoreboard class tracks the role negotiation and checks every result field.
// Depends on slrh_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import slrh_pkg::*;

  // Negotiation phases as tracked by the scoreboard.
  typedef enum logic [2:0] {
    SB_IDLE        = 3'd0,
    SB_MASTER_GO   = 3'd1,
    SB_MASTER_POLL = 3'd2,
    SB_SLAVE_GO    = 3'd3,
    SB_SLAVE_POLL  = 3'd4,
    SB_ACK_GO      = 3'd5,
    SB_ACK_POLL    = 3'd6
  } sb_phase_e;

  // One expected result of a tick.
  typedef struct {
    logic             start;
    logic [ByteW-1:0] send_byte;
    logic             int_clk;
    logic             abort;
    conn_e            link_state;
    side_e            link_side;
  } tick_result_t;

  // Tracks the link negotiation and holds the results still to come.
  class role_tracker;
    logic [ByteW-1:0] sync_val, ack_val, master_lim, slave_lim, ack_lim;
    sb_phase_e        phase;
    logic [ByteW-1:0] wait_ticks;
    side_e            side;
    conn_e            conn;
    tick_result_t     expected_ticks[$];
    int               errors;

    function new();
      sync_val   = SyncByteRst;
      ack_val    = AckByteRst;
      master_lim = MasterTicksRst;
      slave_lim  = SlaveTicksRst;
      ack_lim    = AckTicksRst;
      errors     = 0;
      clear_link();
    endfunction

    function void clear_link();
      phase      = SB_IDLE;
      wait_ticks = '0;
      side       = SIDE_NONE;
      conn       = CONN_DOWN;
    endfunction

    function void set_reg(reg_idx_e idx, logic [ByteW-1:0] val);
      case (idx)
        REG_SYNC_BYTE:    sync_val   = val;
        REG_ACK_BYTE:     ack_val    = val;
        REG_MASTER_TICKS: master_lim = val;
        REG_SLAVE_TICKS:  slave_lim  = val;
        REG_ACK_TICKS:    ack_lim    = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    // Advances the negotiation by one accepted request and stores the result.
    function void predict_tick(logic [InDataW-1:0] req);
      logic             restart, done;
      logic [ByteW-1:0] rx;
      tick_result_t     r;
      restart     = req[0];
      done        = req[1];
      rx          = req[9:2];
      r.start     = 1'b0;
      r.send_byte = '0;
      r.int_clk   = 1'b0;
      r.abort     = 1'b0;
      if (restart) begin
        clear_link();
        r.abort = 1'b1;
      end else begin
        case (phase)
          SB_IDLE: begin
            conn  = CONN_TRYING;
            phase = SB_MASTER_GO;
          end
          SB_MASTER_GO: begin
            r.start     = 1'b1;
            r.send_byte = sync_val;
            r.int_clk   = 1'b1;
            wait_ticks  = '0;
            phase       = SB_MASTER_POLL;
          end
          SB_MASTER_POLL: begin
            wait_ticks = wait_ticks + 8'd1;
            if (done) begin
              if (rx == sync_val) begin
                side  = SIDE_MASTER;
                phase = SB_ACK_GO;
              end else begin
                phase = SB_SLAVE_GO;
              end
            end else if (wait_ticks >= master_lim) begin
              r.abort = 1'b1;
              phase   = SB_SLAVE_GO;
            end
          end
          SB_SLAVE_GO: begin
            r.start     = 1'b1;
            r.send_byte = sync_val;
            wait_ticks  = '0;
            phase       = SB_SLAVE_POLL;
          end
          SB_SLAVE_POLL: begin
            wait_ticks = wait_ticks + 8'd1;
            if (done) begin
              if (rx == sync_val) begin
                side  = SIDE_SLAVE;
                phase = SB_ACK_GO;
              end else begin
                phase = SB_MASTER_GO;
              end
            end else if (wait_ticks >= slave_lim) begin
              r.abort = 1'b1;
              phase   = SB_MASTER_GO;
            end
          end
          SB_ACK_GO: begin
            r.start     = 1'b1;
            r.send_byte = ack_val;
            r.int_clk   = (side == SIDE_MASTER);
            wait_ticks  = '0;
            phase       = SB_ACK_POLL;
          end
          SB_ACK_POLL: begin
            wait_ticks = wait_ticks + 8'd1;
            if (done) begin
              // Either the acknowledge byte or the sync byte confirms the link.
              if (rx == ack_val || rx == sync_val) begin
                conn  = CONN_UP;
                phase = SB_IDLE;
              end else begin
                phase = SB_MASTER_GO;
              end
            end else if (wait_ticks >= ack_lim) begin
              r.abort = 1'b1;
              phase   = SB_MASTER_GO;
            end
          end
          default: phase = SB_IDLE;
        endcase
      end
      r.link_state = conn;
      r.link_side  = side;
      expected_ticks.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_tick(logic [OutDataW-1:0] res);
      tick_result_t e;
      if (expected_ticks.size() == 0) begin
        $error("result 0x%04h arrived with nothing expected", res);
        errors++;
      end else begin
        e = expected_ticks.pop_front();
        compare_field("start_transfer", 32'(e.start), 32'(res[0]));
        compare_field("send_byte", 32'(e.send_byte), 32'(res[8:1]));
        compare_field("internal_clock", 32'(e.int_clk), 32'(res[9]));
        compare_field("abort_transfer", 32'(e.abort), 32'(res[10]));
        compare_field("link_state", 32'(e.link_state), 32'(res[12:11]));
        compare_field("link_side", 32'(e.link_side), 32'(res[14:13]));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  role_tracker sb;
  int          src_idle_pct = 20;
  int          sink_idle_pct = 81;

  serial_link_role_handshake_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each accepted result, then stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        sb.check_tick(m_tdata);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Presents one tick request, with random idle cycles ahead of it.
  task automatic send_tick(input logic restart, input logic done, input logic [7:0] rx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, rx, done, restart};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.predict_tick({6'b0, rx, done, restart});
  endtask

  // Writes one register with an APB setup phase and an access phase.
  task automatic apb_write(input reg_idx_e idx, input logic [ByteW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(ApbDataW-ByteW){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [7:0] sync_v, input logic [7:0] ack_v,
                           input logic [7:0] m_lim, input logic [7:0] s_lim,
                           input logic [7:0] a_lim);
    apb_write(REG_SYNC_BYTE, sync_v);
    apb_write(REG_ACK_BYTE, ack_v);
    apb_write(REG_MASTER_TICKS, m_lim);
    apb_write(REG_SLAVE_TICKS, s_lim);
    apb_write(REG_ACK_TICKS, a_lim);
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int         seg, i, done_pct, sel;
    logic       restart, done;
    logic [7:0] rx;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through both sides, the acknowledge paths and restarts.
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'hFF);
    send_tick(1'b0, 1'b1, 8'hAA);   // master side found
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'h55);   // acknowledge byte confirms
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'h13);   // wrong reply moves to the slave attempt
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'hAA);   // slave side found
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'hAA);   // sync byte also confirms
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'hFF);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);   // master attempt times out
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'hAA);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'h3C);   // bad acknowledge, side is kept
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b1, 1'b1, 8'hFF);   // restart in the middle of a sequence

    done_pct = 35;
    for (seg = 0; seg < 6; seg++) begin
      // Settle the link before touching the registers.
      s_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
      case (seg)
        0: ;
        1: write_all(8'h00, 8'hFF, 8'd1, 8'd1, 8'd1);
        2: write_all(8'hFF, 8'h00, 8'd255, 8'd255, 8'd255);
        default: write_all(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                           8'($urandom_range(1, 12)));
      endcase
      case (seg / 2)
        0: begin
          src_idle_pct  = 20;
          sink_idle_pct = 81;
        end
        1: begin
          src_idle_pct  = 81;
          sink_idle_pct = 20;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (i = 0; i < 175; i++) begin
        // Change how often transfers complete, so that timeouts also occur.
        if (i % 40 == 0) begin
          case ($urandom_range(2))
            0: done_pct = 5;
            1: done_pct = 35;
            default: done_pct = 75;
          endcase
        end
        restart = ($urandom_range(99) < 2);
        done    = ($urandom_range(99) < done_pct);
        sel     = $urandom_range(99);
        if (sel < 45) begin
          rx = sb.sync_val;
        end else if (sel < 70) begin
          rx = sb.ack_val;
        end else begin
          rx = 8'($urandom_range(255));
        end
        send_tick(restart, done, rx);
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/slrh_pkg.sv
hw/rtl/serial_link_role_handshake_top.sv
dv/tb.sv
